/* sv/ptts_pkg.sv */
// Shared types and operation codes for the periodic task tick scheduler.
package ptts_pkg;

  localparam int FuncW  = 3;
  localparam int SlotW  = 3;
  localparam int TimeW  = 16;
  localparam int MaskW  = 8;
  localparam int ExtW   = 7;

  localparam logic [FuncW-1:0] OP_TICK    = 3'd0;
  localparam logic [FuncW-1:0] OP_CREATE  = 3'd1;
  localparam logic [FuncW-1:0] OP_SUSPEND = 3'd2;
  localparam logic [FuncW-1:0] OP_RESUME  = 3'd3;
  localparam logic [FuncW-1:0] OP_DELETE  = 3'd4;

  typedef struct packed {
    logic             occupied;
    logic             running;
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] countdown;
  } slot_rec_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             hit;
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] first_delay;
  } head_cmd_t;

  typedef struct packed {
    logic fire;
    logic refuse;
  } head_flags_t;

endpackage

/* sv/periodic_task_tick_scheduler_unit.sv */
// Top level of the periodic task tick scheduler: ring of slot cells and control.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    func_i slot_i period_i first_delay_i
//   out      output     out_valid_o / out_ready_i  status_o fire_mask_o
//
// Each transfer rotates the slot ring once, one slot past the head cell per cycle
// unless a stalled output holds the last step; the last ring step registers the result.
// Input ready returns the next cycle.
// A new item is taken the cycle after a pass ends, even while a result waits.
// A stalled output holds the last ring step until the output register frees.
// Reset clears every slot; no clearing pass is needed.
module periodic_task_tick_scheduler_unit import ptts_pkg::*; #(
  parameter int TASK_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [FuncW-1:0] func_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [TimeW-1:0] period_i,
  input  logic [TimeW-1:0] first_delay_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             status_o,
  output logic [MaskW-1:0] fire_mask_o
);

  localparam int IdxW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TASK_COUNT - 1);

  slot_rec_t   ring [TASK_COUNT];
  slot_rec_t   head_rec;
  head_cmd_t   cmd;
  head_flags_t flags;

  logic             busy_q, busy_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [FuncW-1:0] func_q, func_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [TimeW-1:0] period_q, period_d;
  logic [TimeW-1:0] delay_q, delay_d;
  logic             acc_status_q, acc_status_d;
  logic [MaskW-1:0] acc_mask_q, acc_mask_d;
  logic             out_valid_q, out_valid_d;
  logic             status_q, status_d;
  logic [MaskW-1:0] mask_q, mask_d;

  logic            in_xfer;
  logic            last;
  logic            step;
  logic [ExtW-1:0] idx_ext;
  logic [ExtW-1:0] slot_ext;
  logic [MaskW-1:0] fire_bits;

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign last       = (idx_q == '0);
  assign step       = busy_q && !(last && out_valid_q && !out_ready_i);

  assign idx_ext  = ExtW'(idx_q);
  assign slot_ext = ExtW'(slot_q);

  assign cmd.func        = func_q;
  assign cmd.hit         = (idx_ext == slot_ext);
  assign cmd.period      = period_q;
  assign cmd.first_delay = delay_q;

  ptts_head u_head (
    .cmd_i   (cmd),
    .rec_i   (ring[TASK_COUNT-1]),
    .rec_o   (head_rec),
    .flags_o (flags)
  );

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    ptts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .rec_i  ((i == 0) ? head_rec : ring[(i == 0) ? 0 : i - 1]),
      .rec_o  (ring[i])
    );
  end

  always_comb begin
    fire_bits = '0;
    for (int b = 0; b < MaskW; b++) begin
      if (flags.fire && idx_ext == ExtW'(b)) begin
        fire_bits[b] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d       = busy_q;
    idx_d        = idx_q;
    func_d       = func_q;
    slot_d       = slot_q;
    period_d     = period_q;
    delay_d      = delay_q;
    acc_status_d = acc_status_q;
    acc_mask_d   = acc_mask_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    mask_d       = mask_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_xfer) begin
      busy_d       = 1'b1;
      idx_d        = LastIdx;
      func_d       = func_i;
      slot_d       = slot_i;
      period_d     = period_i;
      delay_d      = first_delay_i;
      acc_status_d = 1'b0;
      acc_mask_d   = '0;
    end else if (step) begin
      acc_status_d = acc_status_q | flags.refuse;
      acc_mask_d   = acc_mask_q | fire_bits;
      if (last) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
        status_d    = acc_status_q | flags.refuse;
        mask_d      = acc_mask_q | fire_bits;
      end else begin
        idx_d = idx_q - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    slot_q       <= slot_d;
    period_q     <= period_d;
    delay_q      <= delay_d;
    acc_status_q <= acc_status_d;
    acc_mask_q   <= acc_mask_d;
    status_q     <= status_d;
    mask_q       <= mask_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign fire_mask_o = mask_q;

endmodule

/* sv/ptts_cell.sv */
// One slot cell of the rotating ring; loads its neighbor's record on each step.
module ptts_cell import ptts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  slot_rec_t rec_i,
  output slot_rec_t rec_o
);

  slot_rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (step_i) begin
      rec_d = rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

/* sv/ptts_head.sv */
// Update logic applied to the slot record passing the head of the ring.
module ptts_head import ptts_pkg::*; (
  input  head_cmd_t   cmd_i,
  input  slot_rec_t   rec_i,
  output slot_rec_t   rec_o,
  output head_flags_t flags_o
);

  always_comb begin
    rec_o   = rec_i;
    flags_o = '0;
    case (cmd_i.func)
      OP_TICK: begin
        if (rec_i.running) begin
          if (rec_i.countdown == '0) begin
            flags_o.fire    = rec_i.occupied;
            rec_o.countdown = rec_i.period - TimeW'(1);
          end else begin
            rec_o.countdown = rec_i.countdown - TimeW'(1);
          end
        end
      end
      OP_CREATE: begin
        if (cmd_i.hit) begin
          if (rec_i.occupied) begin
            flags_o.refuse = 1'b1;
          end else begin
            rec_o.occupied  = 1'b1;
            rec_o.running   = 1'b1;
            rec_o.period    = cmd_i.period;
            rec_o.countdown = cmd_i.first_delay;
          end
        end
      end
      OP_SUSPEND: begin
        if (cmd_i.hit) begin
          rec_o.running = 1'b0;
        end
      end
      OP_RESUME: begin
        if (cmd_i.hit) begin
          rec_o.running = 1'b1;
        end
      end
      OP_DELETE: begin
        if (cmd_i.hit) begin
          rec_o.occupied = 1'b0;
        end
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end

endmodule

/* sv/ptts_checker.sv */
// Port-level checks for the periodic task tick scheduler, bound to the top level.
module ptts_checker import ptts_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             status_o,
  input logic [MaskW-1:0] fire_mask_o
);

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready during a pass");

  a_result_after_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a pass");

  a_refuse_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> fire_mask_o == '0)
    else $error("refused create reports fired slots");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(fire_mask_o))
    else $error("stalled result changed");

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .fire_mask_o (fire_mask_o)
);

/* verif/tb_top.sv */
// Testbench for the periodic task tick scheduler: directed and random operations checked.
module tb_top import ptts_pkg::*;;

  localparam int TaskCount  = 8;
  localparam int CycleLimit = 500000;
  localparam int LongHold   = 400;

  localparam logic [FuncW-1:0] OpSpareA = 3'd5;
  localparam logic [FuncW-1:0] OpSpareB = 3'd6;
  localparam logic [FuncW-1:0] OpSpareC = 3'd7;

  typedef struct packed {
    logic             status;
    logic [MaskW-1:0] fire_mask;
  } sched_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [FuncW-1:0] func;
  logic [SlotW-1:0] slot;
  logic [TimeW-1:0] period;
  logic [TimeW-1:0] first_delay;
  logic             out_valid;
  logic             out_ready;
  logic             status;
  logic [MaskW-1:0] fire_mask;

  // scheduler state as the block should hold it
  logic             occ_q[TaskCount];
  logic             run_q[TaskCount];
  logic [TimeW-1:0] per_q[TaskCount];
  logic [TimeW-1:0] cnt_q[TaskCount];

  sched_result_t pending_results[$];
  sched_result_t want_r;
  int            mismatch_count;
  int            cycle_count;
  int            tx_idle_pct;
  int            rx_idle_pct;
  logic          rx_long_hold;

  periodic_task_tick_scheduler_unit #(
    .TASK_COUNT(TaskCount)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .slot_i       (slot),
    .period_i     (period),
    .first_delay_i(first_delay),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .fire_mask_o  (fire_mask)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sched_result_t sched_step(input logic [FuncW-1:0] f,
                                               input logic [SlotW-1:0] s,
                                               input logic [TimeW-1:0] p,
                                               input logic [TimeW-1:0] d);
    sched_result_t r;
    r = '0;
    if (f == OP_TICK) begin
      for (int i = 0; i < TaskCount; i++) begin
        if (run_q[i]) begin
          if (cnt_q[i] == '0) begin
            if (occ_q[i] && i < MaskW) r.fire_mask[i] = 1'b1;
            cnt_q[i] = per_q[i] - TimeW'(1);
          end else begin
            cnt_q[i] = cnt_q[i] - TimeW'(1);
          end
        end
      end
    end else if (int'(s) < TaskCount) begin
      case (f)
        OP_CREATE: begin
          if (occ_q[s]) begin
            r.status = 1'b1;
          end else begin
            occ_q[s] = 1'b1;
            run_q[s] = 1'b1;
            per_q[s] = p;
            cnt_q[s] = d;
          end
        end
        OP_SUSPEND: run_q[s] = 1'b0;
        OP_RESUME:  run_q[s] = 1'b1;
        OP_DELETE:  occ_q[s] = 1'b0;
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic logic [TimeW-1:0] pick_interval();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return TimeW'($urandom_range(0, 6));
    if (r < 9) return TimeW'($urandom_range(0, 40));
    return TimeW'($urandom_range(0, 65535));
  endfunction

  task automatic send_op(input logic [FuncW-1:0] f, input logic [SlotW-1:0] s,
                         input logic [TimeW-1:0] p, input logic [TimeW-1:0] d);
    int gap;
    gap = 0;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    func        <= f;
    slot        <= s;
    period      <= p;
    first_delay <= d;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(sched_step(f, s, p, d));
  endtask

  task automatic send_random_ops(input int count);
    logic [FuncW-1:0] f;
    int               pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      f = OP_TICK;
      else if (pick < 68) f = OP_CREATE;
      else if (pick < 77) f = OP_SUSPEND;
      else if (pick < 86) f = OP_RESUME;
      else if (pick < 96) f = OP_DELETE;
      else begin
        case ($urandom_range(0, 2))
          0:       f = OpSpareA;
          1:       f = OpSpareB;
          default: f = OpSpareC;
        endcase
      end
      send_op(f, SlotW'($urandom_range(0, TaskCount - 1)), pick_interval(), pick_interval());
    end
  endtask

  task automatic test_create_refuse();
    send_op(OP_CREATE, 3'd0, 16'd3, 16'd0);
    send_op(OP_CREATE, 3'd0, 16'd9, 16'd9);
    repeat (4) send_op(OP_TICK, 3'd0, 16'd0, 16'd0);
  endtask

  task automatic test_suspend_resume();
    send_op(OP_SUSPEND, 3'd0, 16'd0, 16'd0);
    send_op(OP_TICK, 3'd0, 16'd0, 16'd0);
    send_op(OP_RESUME, 3'd0, 16'd0, 16'd0);
    send_op(OP_TICK, 3'd0, 16'd0, 16'd0);
    // empty slot: only the running mark moves
    send_op(OP_SUSPEND, 3'd5, 16'd0, 16'd0);
    send_op(OP_RESUME, 3'd5, 16'd0, 16'd0);
    send_op(OP_TICK, 3'd0, 16'd0, 16'd0);
  endtask

  task automatic test_delete_and_wrap();
    // deleted slot keeps counting but stays silent
    send_op(OP_DELETE, 3'd0, 16'd0, 16'd0);
    send_op(OP_TICK, 3'd7, 16'hffff, 16'hffff);
    // zero period reloads to the top of the range
    send_op(OP_CREATE, 3'd7, 16'd0, 16'd0);
    send_op(OP_TICK, 3'd0, 16'd0, 16'd0);
    send_op(OP_TICK, 3'd0, 16'd0, 16'd0);
    send_op(OP_CREATE, 3'd6, 16'hffff, 16'hffff);
    send_op(OP_TICK, 3'd0, 16'd0, 16'd0);
  endtask

  task automatic test_unknown_ops();
    send_op(OpSpareA, 3'd1, TimeW'($urandom), TimeW'($urandom));
    send_op(OpSpareB, 3'd7, TimeW'($urandom), TimeW'($urandom));
    send_op(OpSpareC, 3'd0, TimeW'($urandom), TimeW'($urandom));
    send_op(OP_TICK, 3'd0, 16'd0, 16'd0);
  endtask

  task automatic test_random_mix();
    for (int blk = 0; blk < 23; blk++) begin
      tx_idle_pct = 15 * $urandom_range(0, 2);
      rx_idle_pct = 15 * $urandom_range(0, 2);
      send_random_ops(50);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_long_hold = 1'b1;
    send_random_ops(30);
  endtask

  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_ops(200);
  endtask

  // result sink: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_long_hold) begin
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk);
        rx_long_hold = 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual status=%0b fire_mask=%02h",
                 $time, status, fire_mask);
        mismatch_count++;
      end else begin
        want_r = pending_results.pop_front();
        if (status !== want_r.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want_r.status, status);
          mismatch_count++;
        end
        if (fire_mask !== want_r.fire_mask) begin
          $display("%0t: fire_mask expected %02h actual %02h",
                   $time, want_r.fire_mask, fire_mask);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    func           = OP_TICK;
    slot           = '0;
    period         = '0;
    first_delay    = '0;
    mismatch_count = 0;
    tx_idle_pct    = 20;
    rx_idle_pct    = 20;
    rx_long_hold   = 1'b0;
    for (int i = 0; i < TaskCount; i++) begin
      occ_q[i] = 1'b0;
      run_q[i] = 1'b0;
      per_q[i] = '0;
      cnt_q[i] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_create_refuse();
    test_suspend_resume();
    test_delete_and_wrap();
    test_unknown_ops();
    test_random_mix();
    test_backpressure();
    test_full_rate();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * TaskCount) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ptts_pkg.sv
sv/ptts_cell.sv
sv/ptts_head.sv
sv/periodic_task_tick_scheduler_unit.sv
sv/ptts_checker.sv
verif/tb_top.sv
